@@ rtl/vm3d_pkg.sv @@
// shared types and constants of the von mises stress block
package vm3d_pkg;

   // field widths of the words on the ports
   localparam int FIELD_W    = 24;
   localparam int YS_W       = 24;
   localparam int RATIO_W    = 50;
   localparam int EQ_W       = 34;
   localparam int GRAD_W     = 48;
   localparam int GRAD_FRAC  = 40;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // internal fixed widths
   localparam int WIDE_W       = 32;  // widest stress the datapath takes
   localparam int ROOT_W       = 48;  // normalized root for the gradients
   localparam int NORM_TOP     = 95;  // normalized radicand has 95 or 96 bits
   localparam int RATIO_HALF   = 23;  // ratio radicand is shifted by 2*23+1
   localparam int EQ_FRAC_DROP = 16;  // ratio root carries 16 more fraction bits
   localparam int SHIFT_W      = 7;
   localparam int KMAX         = 47;

   // register map
   localparam int REG_YIELD_STRESS = 0;
   localparam logic [YS_W-1:0] YS_RESET = 24'd1;

   localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
   localparam logic [EQ_W-1:0]    EQ_MAX    = '1;

   typedef struct packed {
      logic [FIELD_W-1:0] stress_xx;
      logic [FIELD_W-1:0] stress_yy;
      logic [FIELD_W-1:0] stress_zz;
      logic [FIELD_W-1:0] stress_yz;
      logic [FIELD_W-1:0] stress_xz;
      logic [FIELD_W-1:0] stress_xy;
   } req_type;

   typedef struct packed {
      logic [RATIO_W-1:0] failure_ratio;
      logic [EQ_W-1:0]    equivalent_stress;
      logic [GRAD_W-1:0]  grad_xx;
      logic [GRAD_W-1:0]  grad_yy;
      logic [GRAD_W-1:0]  grad_zz;
      logic [GRAD_W-1:0]  grad_yz;
      logic [GRAD_W-1:0]  grad_xz;
      logic [GRAD_W-1:0]  grad_xy;
   } rsp_type;

endpackage

@@ rtl/vm3d_sqrt_cell.sv @@
// one digit step of the pipelined integer square root
module vm3d_sqrt_cell #(
   parameter int ROOTW = 49,
   parameter int RADW  = 98
) (
   input  logic             clock,
   input  logic             en,
   input  logic [ROOTW:0]   rem_i,
   input  logic [ROOTW-1:0] root_i,
   input  logic [RADW-1:0]  rad_i,
   output logic [ROOTW:0]   rem_o,
   output logic [ROOTW-1:0] root_o,
   output logic [RADW-1:0]  rad_o
);

   logic [ROOTW+2:0] t;
   logic [ROOTW+2:0] trial;
   logic [ROOTW+2:0] diff;
   logic             ge;
   logic [ROOTW:0]   rem_in, rem_ff;
   logic [ROOTW-1:0] root_in, root_ff;
   logic [RADW-1:0]  rad_in, rad_ff;

   // bring down two radicand bits and try the next root bit
   always_comb begin
      t       = {rem_i, rad_i[RADW-1 -: 2]};
      trial   = {1'b0, root_i, 2'b01};
      ge      = (t >= trial);
      diff    = t - trial;
      rem_in  = ge ? diff[ROOTW:0] : t[ROOTW:0];
      root_in = {root_i[ROOTW-2:0], ge};
      rad_in  = {rad_i[RADW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
      end
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign rad_o  = rad_ff;

endmodule

@@ rtl/vm3d_div_cell.sv @@
// one quotient bit of the pipelined restoring divider
module vm3d_div_cell #(
   parameter int DVW = 73,
   parameter int QW  = 49
) (
   input  logic           clock,
   input  logic           en,
   input  logic [DVW-1:0] rem_i,
   input  logic [QW-1:0]  lq_i,
   input  logic [DVW-1:0] d_i,
   output logic [DVW-1:0] rem_o,
   output logic [QW-1:0]  lq_o
);

   logic [DVW:0]   t;
   logic [DVW:0]   diff;
   logic           ge;
   logic [DVW-1:0] rem_in, rem_ff;
   logic [QW-1:0]  lq_in, lq_ff;

   // dividend bits shift out on top while quotient bits shift in below
   always_comb begin
      t      = {rem_i, lq_i[QW-1]};
      ge     = (t >= {1'b0, d_i});
      diff   = t - {1'b0, d_i};
      rem_in = ge ? diff[DVW-1:0] : t[DVW-1:0];
      lq_in  = {lq_i[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         lq_ff  <= lq_in;
      end
   end

   assign rem_o = rem_ff;
   assign lq_o  = lq_ff;

endmodule

@@ rtl/von_mises_3d_failure_with_gradient.sv @@
// von mises equivalent stress, failure ratio and ratio gradients, pipelined
//
//   channel   direction  handshake           word
//   req       in         req_valid/ready     six stress components
//   rsp       out        rsp_valid/ready     ratio, equivalent stress, six gradients
//   csr       in/out     psel/penable/pready yield stress register
//
// one word enters per cycle while req_ready is high; ROOTW, the root width
// (49 at 24-bit stress), is the length of the square-root cell row and of the
// divider cell rows, one result bit per cell.
// reset clears the pipeline valid bits and the output buffer, yield stress to 1.
// a two-word output buffer lets the pipeline run on while a word waits;
// req_ready drops only when both buffer entries are full.
module von_mises_3d_failure_with_gradient #(
   parameter int STRESS_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  vm3d_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output vm3d_pkg::rsp_type                      rsp_data,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [vm3d_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [vm3d_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [vm3d_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready
);

   import vm3d_pkg::*;

   localparam int SB    = STRESS_BITS;
   localparam int MAGW  = SB + 1;
   localparam int SQW   = 2 * MAGW;
   localparam int SHW   = 2 * SB;
   localparam int Q2W   = 2 * SB + 3;
   localparam int BCW   = $clog2(Q2W + 1);
   localparam int RSH   = 2 * RATIO_HALF + 1;
   localparam int RAD0  = (Q2W + RSH > NORM_TOP + 1) ? Q2W + RSH : NORM_TOP + 1;
   localparam int RADW  = ((RAD0 + 1) / 2) * 2;
   localparam int ROOTW = RADW / 2;
   localparam int L     = ROOTW;
   localparam int NMW   = SB + 2;
   localparam int NUMW  = SB + 3;
   localparam int NWID  = NMW + GRAD_FRAC + 1 + KMAX + 1;
   localparam int DENW  = YS_W + ROOT_W;
   localparam int DVW   = DENW + 1;
   localparam int EQRW  = ROOTW - EQ_FRAC_DROP;
   localparam int EQXW  = (EQRW > EQ_W) ? EQRW : EQ_W;
   localparam int RQW   = (ROOTW > RATIO_W) ? ROOTW : RATIO_W;
   localparam int TOT   = 2 * L + 9;
   localparam int HALFY = YS_W;

   typedef struct packed {
      logic [5:0]           neg;
      logic [5:0][NMW-1:0]  mag;
   } num_type;

   typedef struct packed {
      logic               q2z;
      logic [SHIFT_W-1:0] k;
      logic [SHIFT_W-1:0] sa;
      logic [SHIFT_W-1:0] sr;
      num_type            num;
   } sq_side_type;

   typedef struct packed {
      logic            q2z;
      logic [5:0]      neg;
      logic [EQ_W-1:0] eq;
      logic [DVW-1:0]  d;
   } dv_side_type;

   // ---------------------------------------------------------------
   // configuration register
   logic [YS_W-1:0] ys_ff, ys_in;
   logic            csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready &&
                   (paddr[CSR_ADDR_W-1] == 1'(REG_YIELD_STRESS));

   always_comb begin
      ys_in = ys_ff;
      if (csr_wr) begin
         ys_in = pwdata[YS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ys_ff <= YS_RESET;
      end else begin
         ys_ff <= ys_in;
      end
   end

   // register read
   assign prdata = (paddr[CSR_ADDR_W-1] == 1'(REG_YIELD_STRESS)) ?
                   CSR_DATA_W'(ys_ff) : '0;

   // ---------------------------------------------------------------
   // pipeline control and output buffer
   logic [TOT-1:0] vld_ff, vld_in;
   logic [1:0]     count_ff, count_in;
   rsp_type        e0_ff, e0_in, e1_ff, e1_in;
   rsp_type        res;
   logic           adv, push, pop;

   assign adv       = (count_ff != 2'd2);
   assign req_ready = adv;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = e0_ff;
   assign push      = adv && vld_ff[TOT-1];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      vld_in = adv ? {vld_ff[TOT-2:0], req_valid} : vld_ff;
   end

   // two-entry output buffer
   always_comb begin
      count_in = count_ff;
      e0_in    = e0_ff;
      e1_in    = e1_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
         if (count_ff == 2'd0) begin
            e0_in = res;
         end else begin
            e1_in = res;
         end
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
         e0_in    = e1_ff;
      end else if (push && pop) begin
         if (count_ff == 2'd1) begin
            e0_in = res;
         end else begin
            e0_in = e1_ff;
            e1_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         count_ff <= 2'd0;
      end else begin
         vld_ff   <= vld_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

   // ---------------------------------------------------------------
   // front: sign extension, differences, squares, sum, normalization
   logic [FIELD_W-1:0] fld [6];
   logic [SB-1:0]      st_in [6];
   logic [SB-1:0]      st_ff [6];

   always_comb begin
      logic [WIDE_W-1:0] wide;
      fld[0] = req_data.stress_xx;
      fld[1] = req_data.stress_yy;
      fld[2] = req_data.stress_zz;
      fld[3] = req_data.stress_yz;
      fld[4] = req_data.stress_xz;
      fld[5] = req_data.stress_xy;
      for (int i = 0; i < 6; i++) begin
         wide     = {{(WIDE_W-FIELD_W){fld[i][FIELD_W-1]}}, fld[i]};
         st_in[i] = wide[SB-1:0];
      end
   end

   // difference and numerator magnitudes
   logic [MAGW-1:0] md_in [3];
   logic [MAGW-1:0] md_ff [3];
   logic [SB-1:0]   ms_in [3];
   logic [SB-1:0]   ms_ff [3];
   num_type         num_in;
   num_type         n2_ff, n3_ff, n4_ff, n5_ff;

   always_comb begin
      logic [SB:0]     dv;
      logic [NUMW-1:0] e [6];
      logic [NUMW-1:0] n;
      logic [NUMW-1:0] an;
      for (int i = 0; i < 6; i++) begin
         e[i] = {{3{st_ff[i][SB-1]}}, st_ff[i]};
      end
      dv = {st_ff[0][SB-1], st_ff[0]} - {st_ff[1][SB-1], st_ff[1]};
      md_in[0] = dv[SB] ? (~dv + 1'b1) : dv;
      dv = {st_ff[0][SB-1], st_ff[0]} - {st_ff[2][SB-1], st_ff[2]};
      md_in[1] = dv[SB] ? (~dv + 1'b1) : dv;
      dv = {st_ff[1][SB-1], st_ff[1]} - {st_ff[2][SB-1], st_ff[2]};
      md_in[2] = dv[SB] ? (~dv + 1'b1) : dv;
      for (int i = 0; i < 3; i++) begin
         ms_in[i] = st_ff[i+3][SB-1] ? (~st_ff[i+3] + 1'b1) : st_ff[i+3];
      end
      for (int i = 0; i < 6; i++) begin
         case (i)
            0:       n = (e[0] << 1) - e[1] - e[2];
            1:       n = (e[1] << 1) - e[0] - e[2];
            2:       n = (e[2] << 1) - e[0] - e[1];
            default: n = (e[i] << 2) + (e[i] << 1);
         endcase
         an             = n[NUMW-1] ? (~n + 1'b1) : n;
         num_in.neg[i]  = n[NUMW-1];
         num_in.mag[i]  = an[NMW-1:0];
      end
   end

   // squares
   logic [SQW-1:0] sqd_ff [3];
   logic [SHW-1:0] sqs_ff [3];

   // weighted sum: 2Q
   logic [Q2W-1:0] q2_in, q2_ff, q2b_ff;
   always_comb begin
      logic [Q2W-1:0] shs;
      shs   = Q2W'(sqs_ff[0]) + Q2W'(sqs_ff[1]) + Q2W'(sqs_ff[2]);
      q2_in = Q2W'(sqd_ff[0]) + Q2W'(sqd_ff[1]) + Q2W'(sqd_ff[2]) +
              (shs << 2) + (shs << 1);
   end

   // leading one and shift amounts
   logic [SHIFT_W-1:0] k_in, sa_in, sr_in, sh_in;
   logic [SHIFT_W-1:0] k_ff, sa_ff, sr_ff, sh_ff;
   logic               q2z_ff;
   always_comb begin
      logic [BCW-1:0]     b;
      logic [SHIFT_W-1:0] m;
      b = '0;
      for (int i = 0; i < Q2W; i++) begin
         if (q2_ff[i]) begin
            b = BCW'(i + 1);
         end
      end
      k_in  = (SHIFT_W'(NORM_TOP) - SHIFT_W'(b)) >> 1;
      m     = (k_in > SHIFT_W'(RATIO_HALF)) ? k_in : SHIFT_W'(RATIO_HALF);
      sa_in = m - SHIFT_W'(RATIO_HALF);
      sr_in = m - k_in;
      sh_in = (m << 1) + 1'b1;
   end

   // radicand
   logic [RADW-1:0] rad_ff;
   sq_side_type     sq0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff  <= st_in;
         md_ff  <= md_in;
         ms_ff  <= ms_in;
         n2_ff  <= num_in;
         for (int i = 0; i < 3; i++) begin
            sqd_ff[i] <= md_ff[i] * md_ff[i];
            sqs_ff[i] <= SHW'(ms_ff[i]) * SHW'(ms_ff[i]);
         end
         n3_ff  <= n2_ff;
         q2_ff  <= q2_in;
         n4_ff  <= n3_ff;
         q2b_ff <= q2_ff;
         k_ff   <= k_in;
         sa_ff  <= sa_in;
         sr_ff  <= sr_in;
         sh_ff  <= sh_in;
         q2z_ff <= (q2_ff == '0);
         n5_ff  <= n4_ff;
         rad_ff <= RADW'(q2b_ff) << sh_ff;
         sq0_ff <= '{q2z: q2z_ff, k: k_ff, sa: sa_ff, sr: sr_ff, num: n5_ff};
      end
   end

   // ---------------------------------------------------------------
   // square-root cell row
   logic [ROOTW:0]   sq_rem  [0:L];
   logic [ROOTW-1:0] sq_root [0:L];
   logic [RADW-1:0]  sq_rad  [0:L];
   sq_side_type      sq_sb   [0:L];

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_rad[0]  = rad_ff;
   assign sq_sb[0]   = sq0_ff;

   for (genvar i = 0; i < L; i++) begin : g_sqrt
      sq_side_type sb_ff;
      vm3d_sqrt_cell #(.ROOTW(ROOTW), .RADW(RADW)) u_cell (
         .clock  (clock),
         .en     (adv),
         .rem_i  (sq_rem[i]),
         .root_i (sq_root[i]),
         .rad_i  (sq_rad[i]),
         .rem_o  (sq_rem[i+1]),
         .root_o (sq_root[i+1]),
         .rad_o  (sq_rad[i+1])
      );
      always_ff @(posedge clock) begin
         if (adv) begin
            sb_ff <= sq_sb[i];
         end
      end
      assign sq_sb[i+1] = sb_ff;
   end

   // ---------------------------------------------------------------
   // root alignment, denominator, dividends
   logic [ROOTW-1:0]  big_in, big1_ff, big2_ff;
   logic [ROOT_W-1:0] r_in, r_ff;
   logic [EQ_W-1:0]   eq_in, eq1_ff, eq2_ff;
   sq_side_type       sb1_ff;

   always_comb begin
      logic [ROOTW-1:0] rs;
      logic [EQXW-1:0]  eqx;
      big_in = sq_root[L] >> sq_sb[L].sa;
      rs     = sq_root[L] >> sq_sb[L].sr;
      r_in   = rs[ROOT_W-1:0];
      eqx    = EQXW'(big_in >> EQ_FRAC_DROP);
      eq_in  = (eqx > EQXW'(EQ_MAX)) ? EQ_MAX : eqx[EQ_W-1:0];
   end

   logic [2*YS_W-1:0]  pplo_ff, pphi_ff;
   logic [NWID-1:0]    n2w_ff [6];
   logic               q2z2_ff;
   logic [5:0]         neg2_ff;

   logic [DENW-1:0] den;
   logic [NWID-1:0] nn [6];
   always_comb begin
      den = DENW'(pplo_ff) + (DENW'(pphi_ff) << HALFY);
      for (int j = 0; j < 6; j++) begin
         nn[j] = n2w_ff[j] + NWID'(den);
      end
   end

   logic [DVW-1:0] g_rem [6][0:L];
   logic [L-1:0]   g_lq  [6][0:L];
   logic [YS_W-1:0] r_rem [0:L];
   logic [L-1:0]    r_lq  [0:L];
   dv_side_type     dv_sb [0:L];
   logic [DVW-1:0]  grem0_ff [6];
   logic [L-1:0]    glq0_ff  [6];
   logic [L-1:0]    rlq0_ff;
   dv_side_type     dv0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         big1_ff <= big_in;
         r_ff    <= r_in;
         eq1_ff  <= eq_in;
         sb1_ff  <= sq_sb[L];
         pplo_ff <= r_ff[YS_W-1:0] * ys_ff;
         pphi_ff <= r_ff[ROOT_W-1:YS_W] * ys_ff;
         for (int j = 0; j < 6; j++) begin
            n2w_ff[j] <= NWID'(sb1_ff.num.mag[j]) <<
                         (8'(sb1_ff.k) + 8'(GRAD_FRAC + 1));
         end
         big2_ff <= big1_ff;
         eq2_ff  <= eq1_ff;
         q2z2_ff <= sb1_ff.q2z;
         neg2_ff <= sb1_ff.num.neg;
         for (int j = 0; j < 6; j++) begin
            grem0_ff[j] <= DVW'(nn[j] >> L);
            glq0_ff[j]  <= nn[j][L-1:0];
         end
         rlq0_ff <= big2_ff;
         dv0_ff  <= '{q2z: q2z2_ff, neg: neg2_ff, eq: eq2_ff, d: {den, 1'b0}};
      end
   end

   // ---------------------------------------------------------------
   // divider cell rows: six gradients and the ratio
   assign r_rem[0] = '0;
   assign r_lq[0]  = rlq0_ff;
   assign dv_sb[0] = dv0_ff;

   for (genvar j = 0; j < 6; j++) begin : g_grad
      assign g_rem[j][0] = grem0_ff[j];
      assign g_lq[j][0]  = glq0_ff[j];
      for (genvar i = 0; i < L; i++) begin : g_cell
         vm3d_div_cell #(.DVW(DVW), .QW(L)) u_cell (
            .clock (clock),
            .en    (adv),
            .rem_i (g_rem[j][i]),
            .lq_i  (g_lq[j][i]),
            .d_i   (dv_sb[i].d),
            .rem_o (g_rem[j][i+1]),
            .lq_o  (g_lq[j][i+1])
         );
      end
   end

   for (genvar i = 0; i < L; i++) begin : g_ratio
      dv_side_type sb_ff;
      vm3d_div_cell #(.DVW(YS_W), .QW(L)) u_cell (
         .clock (clock),
         .en    (adv),
         .rem_i (r_rem[i]),
         .lq_i  (r_lq[i]),
         .d_i   (ys_ff),
         .rem_o (r_rem[i+1]),
         .lq_o  (r_lq[i+1])
      );
      always_ff @(posedge clock) begin
         if (adv) begin
            sb_ff <= dv_sb[i];
         end
      end
      assign dv_sb[i+1] = sb_ff;
   end

   // ---------------------------------------------------------------
   // result formatting
   always_comb begin
      logic [RQW-1:0]    rq;
      logic [GRAD_W-1:0] g [6];
      logic              ys_zero, gz;
      ys_zero = (ys_ff == '0);
      gz      = ys_zero || dv_sb[L].q2z;
      rq      = RQW'(r_lq[L]);
      for (int j = 0; j < 6; j++) begin
         g[j] = g_lq[j][L][GRAD_W-1:0];
         if (dv_sb[L].neg[j]) begin
            g[j] = ~g[j] + 1'b1;
         end
         if (gz) begin
            g[j] = '0;
         end
      end
      res.equivalent_stress = dv_sb[L].eq;
      if (ys_zero || (rq > RQW'(RATIO_MAX))) begin
         res.failure_ratio = RATIO_MAX;
      end else begin
         res.failure_ratio = rq[RATIO_W-1:0];
      end
      res.grad_xx = g[0];
      res.grad_yy = g[1];
      res.grad_zz = g[2];
      res.grad_yz = g[3];
      res.grad_xz = g[4];
      res.grad_xy = g[5];
   end

endmodule

@@ rtl/vm3d_check.sv @@
// port-level checks of the von mises stress block, bound to the top level
module vm3d_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input vm3d_pkg::rsp_type                rsp_data,
   input logic                             psel,
   input logic                             penable,
   input logic                             pwrite,
   input logic [vm3d_pkg::CSR_ADDR_W-1:0]  paddr,
   input logic [vm3d_pkg::CSR_DATA_W-1:0]  pwdata,
   input logic [vm3d_pkg::CSR_DATA_W-1:0]  prdata,
   input logic                             pready
);

   import vm3d_pkg::*;

   // output buffer is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("word on rsp after reset");

   // input stalls only while output words back up
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req stalled with no word waiting");

   // a waiting word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // zero stress gives zero gradients
   a_zero_grad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.equivalent_stress == '0) |->
         (rsp_data.grad_xx == '0) && (rsp_data.grad_yy == '0) &&
         (rsp_data.grad_zz == '0) && (rsp_data.grad_yz == '0) &&
         (rsp_data.grad_xz == '0) && (rsp_data.grad_xy == '0))
      else $error("nonzero gradient at zero stress");

   // yield stress reads back what was written
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(psel && penable && pwrite && pready &&
         (paddr[CSR_ADDR_W-1] == 1'(REG_YIELD_STRESS))) &&
      (paddr[CSR_ADDR_W-1] == 1'(REG_YIELD_STRESS)) |->
         prdata[YS_W-1:0] == $past(pwdata[YS_W-1:0]))
      else $error("yield stress readback mismatch");

endmodule

bind von_mises_3d_failure_with_gradient vm3d_check u_vm3d_check (.*);
